// ===== rtl/core/npe_pkg.sv =====
package npe_pkg;

    // store capacity and derived widths
    localparam int MAX_LEN = 64;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    typedef logic        [ADDR_W-1:0] t_addr;
    typedef logic        [CNT_W-1:0]  t_cnt;
    typedef logic signed [DATA_W-1:0] t_data;

    // write request into the element store
    typedef struct packed {
        logic  we;
        t_addr addr;
        t_data data;
    } t_ram_wr;

    // sequencer states
    typedef enum logic [3:0] {
        S_LOAD,
        S_S1_START,
        S_SCAN1,
        S_S2_START,
        S_SCAN2,
        S_SWAP_A,
        S_SWAP_B,
        S_E_RD,
        S_E_LD,
        S_E_HOLD
    } t_state;

    // store address of e: prefix kept, suffix after pivot reversed, all if no ascent
    function automatic t_addr emit_addr(t_cnt e, t_cnt piv, t_cnt n, logic found);
        logic [CNT_W:0] base;
        logic [CNT_W:0] diff;
        base = found ? ({1'b0, n} + {1'b0, piv}) : ({1'b0, n} - (CNT_W + 1)'(1));
        diff = base - {1'b0, e};
        return (found && (e <= piv)) ? e[ADDR_W-1:0] : diff[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/core/npe_ram.sv =====
module npe_ram (
    input  logic             i_clk,
    input  npe_pkg::t_ram_wr i_wr,
    input  npe_pkg::t_addr   i_raddr,
    output npe_pkg::t_data   o_rdata
);

    npe_pkg::t_data mem [npe_pkg::MAX_LEN];

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== rtl/core/next_permutation_engine.sv =====
// sequence: load, ascent scan from the right, successor scan, swap of pivot and successor
// (skipped without an ascent), then emit; processing is sequential, no new request is taken
// until the last result is accepted, and every emitted element is a registered store read
// followed by the output register
// reset: synchronous active low, clears count, overflow flag, state and output valid;
// the element store is not cleared
module next_permutation_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [31:0]    i_element,
    input  logic                  i_is_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_element_out,
    output logic                  o_last_out,
    output logic                  o_wrapped,
    output logic                  o_truncated
);

    npe_pkg::t_state  r_state, n_state;
    npe_pkg::t_cnt    r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    npe_pkg::t_addr   r_idx, n_idx;
    logic             r_first, n_first;
    npe_pkg::t_data   r_prev, n_prev;
    npe_pkg::t_cnt    r_piv, n_piv;
    npe_pkg::t_data   r_pv, n_pv;
    npe_pkg::t_addr   r_k, n_k;
    npe_pkg::t_data   r_vk, n_vk;
    logic             r_found, n_found;
    npe_pkg::t_cnt    r_e, n_e;
    logic             r_ovalid, n_ovalid;
    npe_pkg::t_data   r_oelem, n_oelem;
    logic             r_olast, n_olast;

    npe_pkg::t_ram_wr w_wr;
    npe_pkg::t_addr   w_raddr;
    npe_pkg::t_data   w_rdata;

    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_room;
    logic             w_ascent;
    logic             w_greater;
    npe_pkg::t_cnt    w_cnt_after;

    npe_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // handshakes and comparisons
    assign o_in_ready  = (r_state == npe_pkg::S_LOAD);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = r_ovalid && i_out_ready;
    assign w_room      = (r_cnt < npe_pkg::CNT_W'(npe_pkg::MAX_LEN));
    assign w_cnt_after = w_room ? (r_cnt + npe_pkg::CNT_W'(1)) : r_cnt;
    assign w_ascent    = !r_first && (w_rdata < r_prev);
    assign w_greater   = (w_rdata > r_pv);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            npe_pkg::S_LOAD: begin
                if (w_in_acc && i_is_last) n_state = npe_pkg::S_S1_START;
            end
            npe_pkg::S_S1_START: n_state = npe_pkg::S_SCAN1;
            npe_pkg::S_SCAN1: begin
                if (w_ascent)                        n_state = npe_pkg::S_S2_START;
                else if (r_idx == npe_pkg::t_addr'(0)) n_state = npe_pkg::S_E_RD;
            end
            npe_pkg::S_S2_START: n_state = npe_pkg::S_SCAN2;
            npe_pkg::S_SCAN2: begin
                if (w_greater) n_state = npe_pkg::S_SWAP_A;
            end
            npe_pkg::S_SWAP_A: n_state = npe_pkg::S_SWAP_B;
            npe_pkg::S_SWAP_B: n_state = npe_pkg::S_E_RD;
            npe_pkg::S_E_RD:   n_state = npe_pkg::S_E_LD;
            npe_pkg::S_E_LD:   n_state = npe_pkg::S_E_HOLD;
            npe_pkg::S_E_HOLD: begin
                if (w_out_acc) n_state = r_olast ? npe_pkg::S_LOAD : npe_pkg::S_E_LD;
            end
            default: n_state = npe_pkg::S_LOAD;
        endcase
    end

    // datapath and store accesses
    always_comb begin
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_idx    = r_idx;
        n_first  = r_first;
        n_prev   = r_prev;
        n_piv    = r_piv;
        n_pv     = r_pv;
        n_k      = r_k;
        n_vk     = r_vk;
        n_found  = r_found;
        n_e      = r_e;
        n_ovalid = r_ovalid;
        n_oelem  = r_oelem;
        n_olast  = r_olast;
        w_wr     = '0;
        w_raddr  = r_idx;
        case (r_state)
            npe_pkg::S_LOAD: begin
                if (w_in_acc) begin
                    w_wr.we   = w_room;
                    w_wr.addr = r_cnt[npe_pkg::ADDR_W-1:0];
                    w_wr.data = i_element;
                    n_cnt     = w_cnt_after;
                    if (!w_room) n_ovf = 1'b1;
                    n_idx     = npe_pkg::ADDR_W'(w_cnt_after - npe_pkg::CNT_W'(1));
                end
            end
            // scan from the right for the first element below its right neighbour
            npe_pkg::S_S1_START: begin
                w_raddr = r_idx;
                n_first = 1'b1;
                n_e     = '0;
            end
            npe_pkg::S_SCAN1: begin
                w_raddr = r_idx - npe_pkg::t_addr'(1);
                n_first = 1'b0;
                n_prev  = w_rdata;
                if (w_ascent) begin
                    n_found = 1'b1;
                    n_piv   = npe_pkg::CNT_W'(r_idx);
                    n_pv    = w_rdata;
                    n_idx   = npe_pkg::ADDR_W'(r_cnt - npe_pkg::CNT_W'(1));
                end else if (r_idx == npe_pkg::t_addr'(0)) begin
                    n_found = 1'b0;
                end else begin
                    n_idx = r_idx - npe_pkg::t_addr'(1);
                end
            end
            // rightmost element greater than the pivot
            npe_pkg::S_S2_START: begin
                w_raddr = r_idx;
            end
            npe_pkg::S_SCAN2: begin
                w_raddr = r_idx - npe_pkg::t_addr'(1);
                if (w_greater) begin
                    n_k  = r_idx;
                    n_vk = w_rdata;
                end else begin
                    n_idx = r_idx - npe_pkg::t_addr'(1);
                end
            end
            // swap pivot and successor
            npe_pkg::S_SWAP_A: begin
                w_wr.we   = 1'b1;
                w_wr.addr = r_piv[npe_pkg::ADDR_W-1:0];
                w_wr.data = r_vk;
            end
            npe_pkg::S_SWAP_B: begin
                w_wr.we   = 1'b1;
                w_wr.addr = r_k;
                w_wr.data = r_pv;
            end
            // emit, suffix reversed through address mapping
            npe_pkg::S_E_RD: begin
                w_raddr = npe_pkg::emit_addr(r_e, r_piv, r_cnt, r_found);
            end
            npe_pkg::S_E_LD: begin
                n_ovalid = 1'b1;
                n_oelem  = w_rdata;
                n_olast  = (r_e == (r_cnt - npe_pkg::CNT_W'(1)));
            end
            npe_pkg::S_E_HOLD: begin
                w_raddr = npe_pkg::emit_addr(r_e + npe_pkg::CNT_W'(1), r_piv, r_cnt, r_found);
                if (w_out_acc) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_cnt = '0;
                        n_ovf = 1'b0;
                    end else begin
                        n_e = r_e + npe_pkg::CNT_W'(1);
                    end
                end
            end
            default: begin
                w_wr = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= npe_pkg::S_LOAD;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_first <= n_first;
        r_prev  <= n_prev;
        r_piv   <= n_piv;
        r_pv    <= n_pv;
        r_k     <= n_k;
        r_vk    <= n_vk;
        r_found <= n_found;
        r_e     <= n_e;
        r_oelem <= n_oelem;
        r_olast <= n_olast;
    end

    assign o_out_valid   = r_ovalid;
    assign o_element_out = r_oelem;
    assign o_last_out    = r_olast;
    assign o_wrapped     = !r_found;
    assign o_truncated   = r_ovf;

endmodule

// ===== rtl/core/npe_checker.sv =====
module npe_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_is_last,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_element_out,
    input logic        o_last_out
);

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    // a closing request stops further loading
    a_close_stops_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_is_last) |=> !o_in_ready)
        else $error("input still ready after closing request");

    // last result hands back to loading
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_out) |=> (o_in_ready && !o_out_valid))
        else $error("block not back to loading after last result");

    // stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_element_out)
                                           && $stable(o_last_out)))
        else $error("stalled result changed");

endmodule

bind next_permutation_engine npe_sva u_npe_sva (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_is_last     (i_is_last),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_element_out (o_element_out),
    .o_last_out    (o_last_out)
);

// ===== test/npe_checker.sv =====
module npe_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  npe_pkg::t_data i_element,
    input  logic           i_is_last,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  npe_pkg::t_data i_element_out,
    input  logic           i_last_out,
    input  logic           i_wrapped,
    input  logic           i_truncated,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_sequences,
    output int             o_wrap_count,
    output int             o_trunc_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // one emitted element of the successor permutation
    typedef struct {
        npe_pkg::t_data elem;
        logic           last;
        logic           wrapped;
        logic           truncated;
    } t_perm_elem;

    t_perm_elem expected_perm[$];

    // shadow copy of the block's sequence store
    npe_pkg::t_data perm_store[npe_pkg::MAX_LEN];
    int             perm_count    = 0;
    logic           perm_overflow = 1'b0;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_sequences   = 0;
        o_wrap_count  = 0;
        o_trunc_count = 0;
    end

    // swap the span [lo, hi) end for end
    task automatic reverse_span(input int lo, input int hi);
        npe_pkg::t_data tmp;
        while (lo + 1 < hi) begin
            tmp              = perm_store[lo];
            perm_store[lo]   = perm_store[hi-1];
            perm_store[hi-1] = tmp;
            lo++;
            hi--;
        end
    endtask

    // rearrange the stored sequence into its successor and queue every element
    task automatic predict_successor();
        int             n;
        int             pivot;
        int             k;
        logic           found;
        npe_pkg::t_data pv;
        npe_pkg::t_data tmp;
        t_perm_elem     pe;
        n     = perm_count;
        pivot = 0;
        found = 1'b0;
        // rightmost ascent, signed
        for (int i = n; i > 1; i--) begin
            if (perm_store[i-1] > perm_store[i-2]) begin
                pivot = i - 1;
                found = 1'b1;
                break;
            end
        end
        if (!found) begin
            reverse_span(0, n);
        end else begin
            // rightmost later element greater than the pivot value
            pv = perm_store[pivot-1];
            k  = pivot;
            for (int i = pivot + 1; i < n; i++) begin
                if (perm_store[i] > pv)
                    k = i;
            end
            tmp                 = perm_store[pivot-1];
            perm_store[pivot-1] = perm_store[k];
            perm_store[k]       = tmp;
            reverse_span(pivot, n);
        end
        for (int i = 0; i < n; i++) begin
            pe.elem      = perm_store[i];
            pe.last      = (i == n - 1);
            pe.wrapped   = !found;
            pe.truncated = perm_overflow;
            expected_perm.push_back(pe);
        end
        o_sequences++;
        if (!found)
            o_wrap_count++;
        if (perm_overflow)
            o_trunc_count++;
        perm_count    = 0;
        perm_overflow = 1'b0;
    endtask

    // watch both channels, predict on requests, compare on results
    always @(posedge i_clk) begin
        t_perm_elem pe;
        if (i_rst_n) begin
            // accepted request: store it or note the overflow
            if (i_in_valid && i_in_ready) begin
                if (perm_count < npe_pkg::MAX_LEN) begin
                    perm_store[perm_count] = i_element;
                    perm_count++;
                end else begin
                    perm_overflow = 1'b1;
                end
                if (i_is_last)
                    predict_successor();
            end
            // accepted result against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_perm.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result element=%0d last=%b wrap=%b trunc=%b",
                                 $realtime, i_element_out, i_last_out, i_wrapped, i_truncated);
                end else begin
                    pe = expected_perm.pop_front();
                    if (i_element_out !== pe.elem || i_last_out !== pe.last ||
                        i_wrapped !== pe.wrapped || i_truncated !== pe.truncated) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT)
                            $display({"%0t: mismatch expected element=%0d last=%b wrap=%b ",
                                      "trunc=%b, got element=%0d last=%b wrap=%b trunc=%b"},
                                     $realtime, pe.elem, pe.last, pe.wrapped, pe.truncated,
                                     i_element_out, i_last_out, i_wrapped, i_truncated);
                    end
                end
            end
            o_pending = expected_perm.size();
        end
    end

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 256;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 24;

    logic           i_clk         = 1'b0;
    logic           i_rst_n       = 1'b0;
    logic           i_in_valid    = 1'b0;
    npe_pkg::t_data i_element     = '0;
    logic           i_is_last     = 1'b0;
    logic           i_out_ready   = 1'b0;
    logic           o_in_ready;
    logic           o_out_valid;
    npe_pkg::t_data o_element_out;
    logic           o_last_out;
    logic           o_wrapped;
    logic           o_truncated;

    int fail_count;
    int pending;
    int sequences;
    int wrap_count;
    int trunc_count;

    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    // receiver stall pattern
    int        stall_mode   = 0;
    int        stall_timer  = 0;
    logic [7:0] stall_mask  = 8'hff;

    always #6 i_clk = ~i_clk;

    next_permutation_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_element     (i_element),
        .i_is_last     (i_is_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_element_out (o_element_out),
        .o_last_out    (o_last_out),
        .o_wrapped     (o_wrapped),
        .o_truncated   (o_truncated)
    );

    npe_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_element     (i_element),
        .i_is_last     (i_is_last),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_element_out (o_element_out),
        .i_last_out    (o_last_out),
        .i_wrapped     (o_wrapped),
        .i_truncated   (o_truncated),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_sequences   (sequences),
        .o_wrap_count  (wrap_count),
        .o_trunc_count (trunc_count)
    );

    // output ready: random stall mode, redrawn when the stall timer runs out
    always @(posedge i_clk) begin
        if (stall_timer == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_mask  = 8'($urandom);
            stall_timer = 64;
        end
        stall_timer--;
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: begin
                stall_mask  = {stall_mask[6:0], stall_mask[7]};
                i_out_ready <= stall_mask[0] | (stall_mask == 8'h00);
            end
            default: i_out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d idle cycles, %0d results outstanding",
                         idle_cycles, pending);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // sender bursts with random gaps, sometimes long gap-free stretches
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                burst_left = 48;
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 16);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // one request held until accepted
    task automatic send_request(input npe_pkg::t_data elem, input logic last);
        i_in_valid <= 1'b1;
        i_element  <= elem;
        i_is_last  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_sequence(input npe_pkg::t_data seq[$]);
        foreach (seq[i]) begin
            pace_sender();
            send_request(seq[i], i == seq.size() - 1);
        end
    endtask

    // element values: narrow range for duplicates, full range, or extremes
    function automatic npe_pkg::t_data pick_value(input int mode);
        npe_pkg::t_data v;
        case (mode)
            0: v = npe_pkg::t_data'($urandom_range(0, 6)) - 3;
            1: v = npe_pkg::t_data'($urandom);
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        npe_pkg::t_data seq[$];
        int             seq_idx;
        int             len;
        int             mode;
        int             order;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single elements, extremes, signed order, duplicates, wrap
        seq = '{32'h7fff_ffff};                send_sequence(seq);
        seq = '{32'h8000_0000};                send_sequence(seq);
        seq = '{32'h8000_0000, 32'h7fff_ffff}; send_sequence(seq);
        seq = '{32'h7fff_ffff, 32'h8000_0000}; send_sequence(seq);
        seq = '{-1, 0};                        send_sequence(seq);
        seq = '{0, -1};                        send_sequence(seq);
        seq = '{3, 3, 3};                      send_sequence(seq);
        seq = '{1, 2, 2};                      send_sequence(seq);
        seq = '{1, 3, 2};                      send_sequence(seq);
        seq = '{5, 1, 5, 3, 3};                send_sequence(seq);

        // random sequences, one exactly full and one overflowing
        seq_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            if (seq_idx == 3)
                len = npe_pkg::MAX_LEN;
            else if (seq_idx == 9)
                len = npe_pkg::MAX_LEN + $urandom_range(1, 4);
            else if ($urandom_range(0, 5) == 0)
                len = $urandom_range(9, 20);
            else
                len = $urandom_range(1, 8);
            mode  = $urandom_range(0, 2);
            order = $urandom_range(0, 3);
            seq.delete();
            repeat (len) seq.push_back(pick_value(mode));
            if (order == 1)
                seq.rsort();
            else if (order == 2)
                seq.sort();
            send_sequence(seq);
            seq_idx++;
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests in %0d sequences: %0d wrapped, %0d truncated",
                 items_sent, sequences, wrap_count, trunc_count);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d results wrong or unexpected", fail_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/npe_pkg.sv
rtl/core/npe_ram.sv
rtl/core/next_permutation_engine.sv
rtl/core/npe_checker.sv
test/npe_checker.sv
test/tb.sv
